// ===== hw/rtl/sbbc_pkg.sv =====
// ----------------------------------------------------------------------------
// sbbc_pkg
// Shared constants, types and saturation helpers for the band-pass cascade.
// ----------------------------------------------------------------------------
package sbbc_pkg;

	localparam int CHANNELS    = 2;
	localparam int SECTIONS    = 4;
	localparam int SAMPLE_BITS = 24;

	localparam int GAIN_BITS = 32;   // Q1.31
	localparam int COEF_BITS = 32;   // Q2.30
	localparam int W_BITS    = 48;   // Q17.31 delay words
	localparam int W_SPLIT   = 24;   // delay word split for the two partial products
	localparam int COEF_FRAC = 30;
	localparam int OUT_SHIFT = 32 - SAMPLE_BITS;

	localparam int OPB_BITS  = (SAMPLE_BITS > W_SPLIT + 1) ? SAMPLE_BITS : W_SPLIT + 1;
	localparam int PROD_BITS = COEF_BITS + OPB_BITS;
	localparam int ACC_BITS  = W_BITS + 4;

	localparam int CH_BITS   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int SEC_BITS  = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
	localparam int PAIRS     = CHANNELS * SECTIONS;
	localparam int PAIR_BITS = (PAIRS > 1) ? $clog2(PAIRS) : 1;

	localparam int CFG_IDX_BITS  = 8;
	localparam int CFG_DATA_BITS = 2 * COEF_BITS;
	localparam int NUM_CFG       = SECTIONS + 1;
	localparam int CFG_SEC_BASE  = 1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_GAIN = '0;

	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_GAIN,
		MUL_OLD_LO,
		MUL_OLD_HI,
		MUL_NEW_LO,
		MUL_NEW_HI
	} mul_op_t;

	typedef enum logic [2:0] {
		ACC_NONE,
		ACC_GAIN,   // acc <- scaled gain product
		ACC_SUB,    // acc <- acc - m
		ACC_SUBW,   // w   <- sat(acc - m)
		ACC_SECT,   // acc <- sat(section output), delay words update
		ACC_OUT     // channel result <- sat(acc >> OUT_SHIFT)
	} acc_op_t;

	typedef struct packed {
		logic                run;
		mul_op_t             mul;
		logic                comb;
		acc_op_t             acc;
		logic [CH_BITS-1:0]  ch;
		logic [SEC_BITS-1:0] sec;
	} dp_ctrl_t;

	typedef struct packed {
		logic idle;
		logic done;
	} seq_stat_t;

	typedef struct packed {
		logic                     en;
		logic [CFG_IDX_BITS-1:0]  idx;
		logic [CFG_DATA_BITS-1:0] data;
	} cfg_wr_t;

	function automatic logic signed [W_BITS-1:0] sat_w(input logic signed [ACC_BITS-1:0] v);
		logic signed [W_BITS-1:0] r;
		if (v[ACC_BITS-1:W_BITS-1] == {(ACC_BITS-W_BITS+1){v[ACC_BITS-1]}}) begin
			r = v[W_BITS-1:0];
		end else if (v[ACC_BITS-1]) begin
			r = {1'b1, {(W_BITS-1){1'b0}}};
		end else begin
			r = {1'b0, {(W_BITS-1){1'b1}}};
		end
		return r;
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] sat_out(input logic signed [W_BITS-1:0] v);
		logic signed [SAMPLE_BITS-1:0] r;
		if (v[W_BITS-1:SAMPLE_BITS-1] == {(W_BITS-SAMPLE_BITS+1){v[W_BITS-1]}}) begin
			r = v[SAMPLE_BITS-1:0];
		end else if (v[W_BITS-1]) begin
			r = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		end else begin
			r = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/sbbc_in_if.sv =====
// ----------------------------------------------------------------------------
// sbbc_in_if
// Stereo sample channel: valid/ready plus one left/right sample pair.
// ----------------------------------------------------------------------------
interface sbbc_in_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [sbbc_pkg::SAMPLE_BITS-1:0] left_sample;
	logic signed [sbbc_pkg::SAMPLE_BITS-1:0] right_sample;

	modport source (output valid, output left_sample, output right_sample, input ready);
	modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

// ===== hw/rtl/sbbc_out_if.sv =====
// ----------------------------------------------------------------------------
// sbbc_out_if
// Filtered result channel: valid/ready plus one left/right result pair.
// ----------------------------------------------------------------------------
interface sbbc_out_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [sbbc_pkg::SAMPLE_BITS-1:0] left_out;
	logic signed [sbbc_pkg::SAMPLE_BITS-1:0] right_out;

	modport source (output valid, output left_out, output right_out, input ready);
	modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

// ===== hw/rtl/sbbc_cfg_if.sv =====
// ----------------------------------------------------------------------------
// sbbc_cfg_if
// Register write channel: valid/ready, register index and write data.
// ----------------------------------------------------------------------------
interface sbbc_cfg_if;
	logic                                   valid;
	logic                                   ready;
	logic [sbbc_pkg::CFG_IDX_BITS-1:0]      index;
	logic [sbbc_pkg::CFG_DATA_BITS-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/sbbc_seq.sv =====
// ----------------------------------------------------------------------------
// sbbc_seq
// Microcode sequencer: step counter, program ROM, section/channel loops.
// ----------------------------------------------------------------------------
module sbbc_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                out_free,
	output sbbc_pkg::dp_ctrl_t  ctrl,
	output sbbc_pkg::seq_stat_t stat
);

	localparam int PC_BITS = 4;

	typedef logic [PC_BITS-1:0] pc_t;

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_t;
	typedef enum logic [1:0] {JMP_NONE, JMP_SECT, JMP_CHAN} jmp_op_t;

	typedef struct packed {
		sbbc_pkg::mul_op_t mul;
		logic              comb;
		sbbc_pkg::acc_op_t acc;
		jmp_op_t           jmp;
		pc_t               target;
	} uword_t;

	// program steps
	localparam pc_t S_GMUL    = pc_t'(0);
	localparam pc_t S_GACC    = pc_t'(1);
	localparam pc_t S_OLD_LO  = pc_t'(2);
	localparam pc_t S_OLD_HI  = pc_t'(3);
	localparam pc_t S_NEW_LO  = pc_t'(4);
	localparam pc_t S_NEW_HI  = pc_t'(5);
	localparam pc_t S_NEW_CMB = pc_t'(6);
	localparam pc_t S_WSAT    = pc_t'(7);
	localparam pc_t S_SECT    = pc_t'(8);
	localparam pc_t S_OUT     = pc_t'(9);

	function automatic uword_t rom(input pc_t pc);
		uword_t u;
		u.mul    = sbbc_pkg::MUL_NONE;
		u.comb   = 1'b0;
		u.acc    = sbbc_pkg::ACC_NONE;
		u.jmp    = JMP_NONE;
		u.target = S_GMUL;
		case (pc)
			S_GMUL:    u.mul = sbbc_pkg::MUL_GAIN;
			S_GACC:    u.acc = sbbc_pkg::ACC_GAIN;
			S_OLD_LO:  u.mul = sbbc_pkg::MUL_OLD_LO;
			S_OLD_HI:  u.mul = sbbc_pkg::MUL_OLD_HI;
			S_NEW_LO: begin
				u.comb = 1'b1;
				u.mul  = sbbc_pkg::MUL_NEW_LO;
			end
			S_NEW_HI: begin
				u.acc = sbbc_pkg::ACC_SUB;
				u.mul = sbbc_pkg::MUL_NEW_HI;
			end
			S_NEW_CMB: u.comb = 1'b1;
			S_WSAT:    u.acc = sbbc_pkg::ACC_SUBW;
			S_SECT: begin
				u.acc    = sbbc_pkg::ACC_SECT;
				u.jmp    = JMP_SECT;
				u.target = S_OLD_LO;
			end
			S_OUT: begin
				u.acc    = sbbc_pkg::ACC_OUT;
				u.jmp    = JMP_CHAN;
				u.target = S_GMUL;
			end
			default: u.jmp = JMP_NONE;
		endcase
		return u;
	endfunction

	state_t                        state_q;
	pc_t                           pc_q;
	logic [sbbc_pkg::SEC_BITS-1:0] sec_q;
	logic [sbbc_pkg::CH_BITS-1:0]  ch_q;
	uword_t                        uw;

	assign uw = rom(pc_q);

	always_comb begin
		ctrl.run  = (state_q == ST_RUN);
		ctrl.mul  = uw.mul;
		ctrl.comb = uw.comb;
		ctrl.acc  = uw.acc;
		ctrl.ch   = ch_q;
		ctrl.sec  = sec_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pc_q      <= S_GMUL;
			sec_q     <= '0;
			ch_q      <= '0;
			stat.idle <= 1'b1;
			stat.done <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q   <= ST_RUN;
						pc_q      <= S_GMUL;
						sec_q     <= '0;
						ch_q      <= '0;
						stat.idle <= 1'b0;
					end
				end
				ST_RUN: begin
					case (uw.jmp)
						JMP_SECT: begin
							if (sec_q != sbbc_pkg::SEC_BITS'(sbbc_pkg::SECTIONS - 1)) begin
								sec_q <= sec_q + sbbc_pkg::SEC_BITS'(1);
								pc_q  <= uw.target;
							end else begin
								sec_q <= '0;
								pc_q  <= pc_q + pc_t'(1);
							end
						end
						JMP_CHAN: begin
							if (ch_q != sbbc_pkg::CH_BITS'(sbbc_pkg::CHANNELS - 1)) begin
								ch_q <= ch_q + sbbc_pkg::CH_BITS'(1);
								pc_q <= uw.target;
							end else begin
								state_q   <= ST_DONE;
								stat.done <= 1'b1;
							end
						end
						default: pc_q <= pc_q + pc_t'(1);
					endcase
				end
				ST_DONE: begin
					if (out_free) begin
						state_q   <= ST_IDLE;
						stat.done <= 1'b0;
						stat.idle <= 1'b1;
					end
				end
				default: begin
					state_q   <= ST_IDLE;
					stat.idle <= 1'b1;
					stat.done <= 1'b0;
				end
			endcase
		end
	end

	// program counter never leaves the program while running
	a_pc_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (pc_q <= S_OUT))
		else $error("sequencer step outside program");

	// channel only advances from the output step
	a_ch_step: assert property (@(posedge clk) disable iff (!arst_n)
		($past(state_q) == ST_RUN && ch_q != $past(ch_q)) |-> ($past(pc_q) == S_OUT))
		else $error("channel advanced outside output step");

endmodule

// ===== hw/rtl/sbbc_dpath.sv =====
// ----------------------------------------------------------------------------
// sbbc_dpath
// Shared multiplier datapath, accumulator, delay words and config registers.
// ----------------------------------------------------------------------------
module sbbc_dpath (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  sbbc_pkg::cfg_wr_t                       cfg_wr,
	input  logic                                    load,
	input  logic signed [sbbc_pkg::SAMPLE_BITS-1:0] smp [sbbc_pkg::CHANNELS],
	input  sbbc_pkg::dp_ctrl_t                      ctrl,
	output logic signed [sbbc_pkg::SAMPLE_BITS-1:0] res [sbbc_pkg::CHANNELS]
);

	logic signed [sbbc_pkg::GAIN_BITS-1:0]   gain_q;
	logic signed [sbbc_pkg::COEF_BITS-1:0]   c_old_q [sbbc_pkg::SECTIONS];
	logic signed [sbbc_pkg::COEF_BITS-1:0]   c_new_q [sbbc_pkg::SECTIONS];
	logic signed [sbbc_pkg::W_BITS-1:0]      dw2_q   [sbbc_pkg::PAIRS];
	logic signed [sbbc_pkg::W_BITS-1:0]      dw1_q   [sbbc_pkg::PAIRS];

	logic signed [sbbc_pkg::SAMPLE_BITS-1:0] x_q     [sbbc_pkg::CHANNELS];
	logic signed [sbbc_pkg::SAMPLE_BITS-1:0] res_q   [sbbc_pkg::CHANNELS];
	logic signed [sbbc_pkg::PROD_BITS-1:0]   prod_q;
	logic signed [sbbc_pkg::PROD_BITS-1:0]   lo_q;
	logic signed [sbbc_pkg::ACC_BITS-1:0]    m_q;
	logic signed [sbbc_pkg::ACC_BITS-1:0]    acc_q;
	logic signed [sbbc_pkg::W_BITS-1:0]      wn_q;

	logic [sbbc_pkg::PAIR_BITS-1:0]          pair;
	logic signed [sbbc_pkg::W_BITS-1:0]      w2_sel;
	logic signed [sbbc_pkg::W_BITS-1:0]      w1_sel;
	logic signed [sbbc_pkg::W_BITS-1:0]      w_mul;
	logic signed [sbbc_pkg::COEF_BITS-1:0]   op_a;
	logic signed [sbbc_pkg::OPB_BITS-1:0]    op_b;
	logic signed [sbbc_pkg::PROD_BITS-1:0]   prod_d;
	logic signed [sbbc_pkg::PROD_BITS:0]     cmb_sum;
	logic signed [sbbc_pkg::ACC_BITS-1:0]    m_d;
	logic signed [sbbc_pkg::ACC_BITS-1:0]    sub_d;
	logic signed [sbbc_pkg::ACC_BITS-1:0]    w1x2;
	logic signed [sbbc_pkg::ACC_BITS-1:0]    sec_sum;
	logic signed [sbbc_pkg::W_BITS-1:0]      out_sh;
	logic                                    first_half;
	logic                                    sect_wr;

	assign pair   = sbbc_pkg::PAIR_BITS'(int'(ctrl.ch) * sbbc_pkg::SECTIONS + int'(ctrl.sec));
	assign w2_sel = dw2_q[pair];
	assign w1_sel = dw1_q[pair];

	// operand select for the shared multiplier
	always_comb begin
		w_mul = w1_sel;
		op_a  = '0;
		op_b  = '0;
		case (ctrl.mul)
			sbbc_pkg::MUL_GAIN: begin
				op_a = gain_q;
				op_b = sbbc_pkg::OPB_BITS'(x_q[ctrl.ch]);
			end
			sbbc_pkg::MUL_OLD_LO: begin
				w_mul = w2_sel;
				op_a  = c_old_q[ctrl.sec];
				op_b  = sbbc_pkg::OPB_BITS'($signed({1'b0, w_mul[sbbc_pkg::W_SPLIT-1:0]}));
			end
			sbbc_pkg::MUL_OLD_HI: begin
				w_mul = w2_sel;
				op_a  = c_old_q[ctrl.sec];
				op_b  = sbbc_pkg::OPB_BITS'(
					$signed(w_mul[sbbc_pkg::W_BITS-1:sbbc_pkg::W_SPLIT]));
			end
			sbbc_pkg::MUL_NEW_LO: begin
				op_a = c_new_q[ctrl.sec];
				op_b = sbbc_pkg::OPB_BITS'($signed({1'b0, w_mul[sbbc_pkg::W_SPLIT-1:0]}));
			end
			sbbc_pkg::MUL_NEW_HI: begin
				op_a = c_new_q[ctrl.sec];
				op_b = sbbc_pkg::OPB_BITS'(
					$signed(w_mul[sbbc_pkg::W_BITS-1:sbbc_pkg::W_SPLIT]));
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	assign prod_d = op_a * op_b;

	// floor(c*w / 2^30) from hi and lo partial products; low 24 bits of lo
	// cannot carry into the result
	assign cmb_sum = prod_q + (lo_q >>> sbbc_pkg::W_SPLIT);
	assign m_d     = sbbc_pkg::ACC_BITS'(cmb_sum >>> (sbbc_pkg::COEF_FRAC - sbbc_pkg::W_SPLIT));
	assign sub_d   = acc_q - m_q;

	assign first_half = ({1'b0, ctrl.sec} <
		(sbbc_pkg::SEC_BITS + 1)'(sbbc_pkg::SECTIONS / 2));
	assign w1x2    = sbbc_pkg::ACC_BITS'(w1_sel) <<< 1;
	assign sec_sum = first_half ?
		sbbc_pkg::ACC_BITS'(w2_sel) - w1x2 + sbbc_pkg::ACC_BITS'(wn_q) :
		sbbc_pkg::ACC_BITS'(w2_sel) + w1x2 + sbbc_pkg::ACC_BITS'(wn_q);

	assign out_sh  = $signed(acc_q[sbbc_pkg::W_BITS-1:0]) >>> sbbc_pkg::OUT_SHIFT;
	assign sect_wr = ctrl.run && (ctrl.acc == sbbc_pkg::ACC_SECT);

	always_ff @(posedge clk) begin
		if (load) begin
			x_q <= smp;
		end
		if (ctrl.run) begin
			if (ctrl.mul != sbbc_pkg::MUL_NONE) begin
				prod_q <= prod_d;
			end
			if (ctrl.mul == sbbc_pkg::MUL_OLD_HI || ctrl.mul == sbbc_pkg::MUL_NEW_HI) begin
				lo_q <= prod_q;
			end
			if (ctrl.comb) begin
				m_q <= m_d;
			end
			case (ctrl.acc)
				sbbc_pkg::ACC_GAIN:
					acc_q <= sbbc_pkg::ACC_BITS'(prod_q >>> (sbbc_pkg::SAMPLE_BITS - 1));
				sbbc_pkg::ACC_SUB:  acc_q <= sub_d;
				sbbc_pkg::ACC_SUBW: wn_q  <= sbbc_pkg::sat_w(sub_d);
				sbbc_pkg::ACC_SECT: acc_q <= sbbc_pkg::ACC_BITS'(sbbc_pkg::sat_w(sec_sum));
				sbbc_pkg::ACC_OUT:  res_q[ctrl.ch] <= sbbc_pkg::sat_out(out_sh);
				default: acc_q <= acc_q;
			endcase
		end
	end

	// config registers and delay words; any listed register write clears state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= '0;
			for (int i = 0; i < sbbc_pkg::SECTIONS; i++) begin
				c_old_q[i] <= '0;
				c_new_q[i] <= '0;
			end
			for (int i = 0; i < sbbc_pkg::PAIRS; i++) begin
				dw2_q[i] <= '0;
				dw1_q[i] <= '0;
			end
		end else if (cfg_wr.en) begin
			if (cfg_wr.idx == sbbc_pkg::CFG_GAIN) begin
				gain_q <= cfg_wr.data[sbbc_pkg::GAIN_BITS-1:0];
			end
			for (int i = 0; i < sbbc_pkg::SECTIONS; i++) begin
				if (cfg_wr.idx == sbbc_pkg::CFG_IDX_BITS'(sbbc_pkg::CFG_SEC_BASE + i)) begin
					c_old_q[i] <= cfg_wr.data[2*sbbc_pkg::COEF_BITS-1:sbbc_pkg::COEF_BITS];
					c_new_q[i] <= cfg_wr.data[sbbc_pkg::COEF_BITS-1:0];
				end
			end
			if (cfg_wr.idx < sbbc_pkg::CFG_IDX_BITS'(sbbc_pkg::NUM_CFG)) begin
				for (int i = 0; i < sbbc_pkg::PAIRS; i++) begin
					dw2_q[i] <= '0;
					dw1_q[i] <= '0;
				end
			end
		end else if (sect_wr) begin
			dw2_q[pair] <= w1_sel;
			dw1_q[pair] <= wn_q;
		end
	end

	assign res = res_q;

endmodule

// ===== hw/rtl/stereo_bessel_bandpass_cascade_top.sv =====
// ----------------------------------------------------------------------------
// stereo_bessel_bandpass_cascade_top
// Stereo eighth-order band-pass filter: four DF-II biquads per channel.
// ----------------------------------------------------------------------------
// Each accepted frame (left and right Q1.23 samples) runs through a cascade
// of four direct-form-II sections per channel, with the input gain applied
// before the first section, and returns one frame of saturated Q1.23 results.
// A frame runs as the accept, 31 microcode steps per channel (2 for the gain,
// 7 per section, 1 for the output), and a move into the output register once
// that register is free. The 7 steps per section come from the single shared
// 32x25 multiplier, which needs a low and a high partial product for each of
// the two feedback terms. While a result sits in the output register the next
// frame can already be accepted. Any write to a listed register clears all
// delay words in the same cycle (no clearing pass); writes to unlisted indexes
// are ignored. Registers must only be written while the filter is idle; cfg is
// always ready.
// ----------------------------------------------------------------------------
module stereo_bessel_bandpass_cascade_top (
	input logic        clk,
	input logic        arst_n,
	sbbc_in_if.sink    sample_ch,
	sbbc_out_if.source result_ch,
	sbbc_cfg_if.sink   cfg
);

	sbbc_pkg::dp_ctrl_t                      ctrl;
	sbbc_pkg::seq_stat_t                     stat;
	sbbc_pkg::cfg_wr_t                       cfg_wr;

	logic                                    start;
	logic                                    out_free;
	logic                                    out_load;
	logic                                    out_valid_q;
	logic signed [sbbc_pkg::SAMPLE_BITS-1:0] out_left_q;
	logic signed [sbbc_pkg::SAMPLE_BITS-1:0] out_right_q;
	logic signed [sbbc_pkg::SAMPLE_BITS-1:0] smp [sbbc_pkg::CHANNELS];
	logic signed [sbbc_pkg::SAMPLE_BITS-1:0] res [sbbc_pkg::CHANNELS];

	// input transaction: only taken while the sequencer is idle
	assign sample_ch.ready = stat.idle;
	assign start           = sample_ch.valid & sample_ch.ready;
	assign smp[0]          = sample_ch.left_sample;
	assign smp[1]          = sample_ch.right_sample;

	// register writes are always accepted and never stall
	assign cfg.ready   = 1'b1;
	assign cfg_wr.en   = cfg.valid;
	assign cfg_wr.idx  = cfg.index;
	assign cfg_wr.data = cfg.data;

	// output register decouples the sequencer from a stalled consumer
	assign out_free = !out_valid_q || result_ch.ready;
	assign out_load = stat.done && out_free;

	sbbc_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.out_free (out_free),
		.ctrl     (ctrl),
		.stat     (stat)
	);

	sbbc_dpath u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg_wr (cfg_wr),
		.load   (start),
		.smp    (smp),
		.ctrl   (ctrl),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_left_q  <= res[0];
			out_right_q <= res[1];
		end
	end

	assign result_ch.valid     = out_valid_q;
	assign result_ch.left_out  = out_left_q;
	assign result_ch.right_out = out_right_q;

	// an accepted frame starts the sequencer
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> !stat.idle)
		else $error("accepted frame did not start sequencer");

	// a finished frame waits until the output register frees up
	a_done_held: assert property (@(posedge clk) disable iff (!arst_n)
		(stat.done && !out_free) |=> stat.done)
		else $error("finished frame dropped while output stalled");

	// the output register captures the finished channel results
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (out_valid_q && out_left_q == $past(res[0])
			&& out_right_q == $past(res[1])))
		else $error("output register did not capture results");

endmodule

// ===== dv/tb_stereo_bessel_bandpass_cascade_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stereo_bessel_bandpass_cascade_top
// Self-checking bench for the stereo four-section band-pass cascade.
// ----------------------------------------------------------------------------
// Drives stereo frames into the filter and programs its gain and coefficient
// registers between phases. A bit-true predictor runs alongside the DUT, and
// every filtered frame is checked against it in order. Directed tests cover
// the reset defaults, the gain extremes, the coefficient extremes with state
// saturation, and the register decode. Random tests then run stable filter
// settings and fully random settings under random idling on both sides, plus
// one long result stall that backs the filter up.
// ----------------------------------------------------------------------------
module tb_stereo_bessel_bandpass_cascade_top;

	// filter geometry and register map
	localparam int CHANNELS      = sbbc_pkg::CHANNELS;
	localparam int SECTIONS      = sbbc_pkg::SECTIONS;
	localparam int SAMPLE_BITS   = sbbc_pkg::SAMPLE_BITS;
	localparam int GAIN_BITS     = sbbc_pkg::GAIN_BITS;
	localparam int COEF_BITS     = sbbc_pkg::COEF_BITS;
	localparam int W_BITS        = sbbc_pkg::W_BITS;
	localparam int COEF_FRAC     = sbbc_pkg::COEF_FRAC;
	localparam int OUT_SHIFT     = sbbc_pkg::OUT_SHIFT;
	localparam int CFG_IDX_BITS  = sbbc_pkg::CFG_IDX_BITS;
	localparam int CFG_DATA_BITS = sbbc_pkg::CFG_DATA_BITS;
	localparam int NUM_CFG       = sbbc_pkg::NUM_CFG;
	localparam int CFG_SEC_BASE  = sbbc_pkg::CFG_SEC_BASE;
	localparam logic [CFG_IDX_BITS-1:0] CFG_GAIN = sbbc_pkg::CFG_GAIN;

	localparam int CLK_PERIOD     = 4;
	localparam int RESET_CYCLES   = 7;
	localparam int MAX_GAP        = 17;
	localparam int HOLD_CYCLES    = 600;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int TAIL_CYCLES    = 160;
	localparam int REPORT_LIMIT   = 10;

	// indexes with no register behind them
	localparam logic [CFG_IDX_BITS-1:0] IDX_PAST_LIST = CFG_IDX_BITS'(NUM_CFG);
	localparam logic [CFG_IDX_BITS-1:0] IDX_TOP       = '1;

	// delay word and output saturation limits
	localparam longint W_MAX = (longint'(1) << (W_BITS - 1)) - 1;
	localparam longint W_MIN = -W_MAX - 1;
	localparam longint S_MAX = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
	localparam longint S_MIN = -S_MAX - 1;

	// stable sections: older-tap coef in [0.5, 0.99] (Q2.30)
	localparam int unsigned POLE_SQ_LO = 32'd536870912;
	localparam int unsigned POLE_SQ_HI = 32'd1063004405;
	localparam int unsigned GAIN_SMALL = 32'd1 << 26;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [COEF_BITS-1:0]   coef_t;
	typedef logic [CFG_DATA_BITS-1:0]      reg_word_t;
	typedef logic [GAIN_BITS-1:0]          gain_word_t;
	typedef struct packed {
		sample_t left;
		sample_t right;
	} frame_t;

	localparam sample_t    SAMPLE_MAX    = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam sample_t    SAMPLE_MIN    = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam gain_word_t GAIN_MAX      = {1'b0, {(GAIN_BITS-1){1'b1}}};
	localparam gain_word_t GAIN_MIN      = {1'b1, {(GAIN_BITS-1){1'b0}}};
	localparam reg_word_t  COEF_MAX_PAIR = {2{1'b0, {(COEF_BITS-1){1'b1}}}};
	localparam reg_word_t  COEF_MIN_PAIR = {2{1'b1, {(COEF_BITS-1){1'b0}}}};

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	sbbc_in_if  sample_ch ();
	sbbc_out_if result_ch ();
	sbbc_cfg_if cfg ();

	stereo_bessel_bandpass_cascade_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_ch (sample_ch),
		.result_ch (result_ch),
		.cfg       (cfg)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor state: registers and delay words as the filter sees them
	// ------------------------------------------------------------------
	logic signed [GAIN_BITS-1:0] gain_q31;
	coef_t  fb_old [SECTIONS];
	coef_t  fb_new [SECTIONS];
	longint w_older [CHANNELS][SECTIONS];
	longint w_newer [CHANNELS][SECTIONS];

	// filtered frames still owed by the DUT, oldest first
	frame_t filtered_pending [$];

	// idling controls shared by the test tasks and the two sides
	bit          tx_no_idle;
	bit          rx_no_idle;
	int unsigned rx_hold;

	int unsigned err_count;
	int unsigned frames_sent;
	int unsigned results_checked;
	int unsigned reg_writes;
	int unsigned settings_loaded;
	int unsigned idle_cycles;

	function automatic longint clamp_w(input longint v);
		if (v > W_MAX)
			return W_MAX;
		else if (v < W_MIN)
			return W_MIN;
		return v;
	endfunction

	// floor(c * w / 2^30); the full product needs up to 80 bits
	function automatic longint fb_product(input coef_t c, input longint w);
		logic signed [95:0] p;
		p = c * w;
		return longint'(p >>> COEF_FRAC);
	endfunction

	function automatic void clear_delay_words();
		for (int ch = 0; ch < CHANNELS; ch++) begin
			for (int s = 0; s < SECTIONS; s++) begin
				w_older[ch][s] = 0;
				w_newer[ch][s] = 0;
			end
		end
	endfunction

	// register write as the filter decodes it; listed writes flush the state
	function automatic void apply_reg(input logic [CFG_IDX_BITS-1:0] idx, input reg_word_t val);
		if (idx == CFG_GAIN) begin
			gain_q31 = val[GAIN_BITS-1:0];
			clear_delay_words();
		end else if (idx >= CFG_SEC_BASE && idx < NUM_CFG) begin
			fb_old[idx - CFG_SEC_BASE] = val[2*COEF_BITS-1:COEF_BITS];
			fb_new[idx - CFG_SEC_BASE] = val[COEF_BITS-1:0];
			clear_delay_words();
		end
	endfunction

	// run one frame through both cascades and advance the delay words
	function automatic frame_t filter_frame(input frame_t in_f);
		frame_t  out_f;
		sample_t x;
		longint  v;
		longint  w;
		longint  w1;
		longint  w2;
		longint  r;
		for (int ch = 0; ch < CHANNELS; ch++) begin
			x = (ch == 0) ? in_f.left : in_f.right;
			// Q1.23 * Q1.31 -> Q17.31 word, floor
			v = (longint'(x) * longint'(gain_q31)) >>> (SAMPLE_BITS - 1);
			for (int s = 0; s < SECTIONS; s++) begin
				w2 = w_older[ch][s];
				w1 = w_newer[ch][s];
				w  = clamp_w(v - fb_product(fb_old[s], w2) - fb_product(fb_new[s], w1));
				// high-pass zeros in the first half, low-pass zeros in the second
				if (s < SECTIONS / 2)
					v = clamp_w(w2 - 2 * w1 + w);
				else
					v = clamp_w(w2 + 2 * w1 + w);
				w_older[ch][s] = w1;
				w_newer[ch][s] = w;
			end
			r = v >>> OUT_SHIFT;
			if (r > S_MAX)
				r = S_MAX;
			else if (r < S_MIN)
				r = S_MIN;
			if (ch == 0)
				out_f.left = sample_t'(r);
			else
				out_f.right = sample_t'(r);
		end
		return out_f;
	endfunction

	function automatic void log_error(input string msg);
		err_count++;
		if (err_count <= REPORT_LIMIT)
			$display("[%0t] MISMATCH %s", $time, msg);
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic sample_t random_sample();
		case ($urandom_range(7, 0))
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			default: return sample_t'($urandom);
		endcase
	endfunction

	function automatic gain_word_t random_gain(input bit full_range);
		gain_word_t g;
		if (full_range) begin
			g = $urandom;
		end else begin
			g = $urandom_range(GAIN_SMALL, 0);
			if ($urandom_range(1, 0) != 0)
				g = -g;
		end
		return g;
	endfunction

	// coef pair inside the biquad stability triangle:
	// 0 < c_old < 1 and |c_new| < 1 + c_old
	function automatic reg_word_t stable_pair();
		int unsigned c_old;
		int unsigned lim;
		coef_t       c_new;
		c_old = $urandom_range(POLE_SQ_HI, POLE_SQ_LO);
		lim   = (32'd1 << COEF_FRAC) + c_old - 1;
		c_new = $urandom_range(lim, 0);
		if ($urandom_range(1, 0) != 0)
			c_new = -c_new;
		return {c_old, c_new};
	endfunction

	// one register transaction; valid stays up so writes can go back to back
	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input reg_word_t val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= val;
		do @(posedge clk); while (!cfg.ready);
		apply_reg(idx, val);
		reg_writes++;
	endtask

	// hold the input side until every owed frame has come back
	task automatic wait_drained();
		sample_ch.valid <= 1'b0;
		while (filtered_pending.size() != 0)
			@(posedge clk);
	endtask

	// program gain and all four sections; only done with the filter idle
	task automatic load_settings(input gain_word_t gain, input reg_word_t pairs [SECTIONS]);
		wait_drained();
		// upper half of the gain word is unused, so fill it with noise
		write_reg(CFG_GAIN, {gain_word_t'($urandom), gain});
		for (int s = 0; s < SECTIONS; s++)
			write_reg(CFG_IDX_BITS'(CFG_SEC_BASE + s), pairs[s]);
		cfg.valid <= 1'b0;
		settings_loaded++;
	endtask

	// one input transaction with a random lead-in gap; valid is left high
	// afterward so the next frame can follow without a bubble
	task automatic push_frame(input sample_t l, input sample_t r);
		int unsigned gap;
		frame_t      f;
		gap = tx_no_idle ? 0 : $urandom_range(MAX_GAP, 0);
		if (gap != 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid        <= 1'b1;
		sample_ch.left_sample  <= l;
		sample_ch.right_sample <= r;
		do @(posedge clk); while (!sample_ch.ready);
		f.left  = l;
		f.right = r;
		filtered_pending.push_back(filter_frame(f));
		frames_sent++;
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// registers come out of reset at zero, so everything filters to zero
	task automatic test_reset_defaults();
		push_frame(SAMPLE_MAX, SAMPLE_MIN);
		push_frame(SAMPLE_MIN, SAMPLE_MAX);
		push_frame('0, -1);
	endtask

	// zero feedback turns each channel into a pure FIR; full-scale steps
	// push the section sums into output saturation
	task automatic test_gain_extremes();
		reg_word_t pairs [SECTIONS];
		pairs = '{default: '0};
		load_settings(GAIN_MAX, pairs);
		push_frame(SAMPLE_MAX, SAMPLE_MIN);
		push_frame(SAMPLE_MAX, SAMPLE_MIN);
		push_frame('0, '0);
		push_frame(SAMPLE_MIN, SAMPLE_MAX);
		push_frame(1, -1);
		push_frame(-1, 1);
		// -1.0 gain times the most negative sample gives +1.0
		load_settings(GAIN_MIN, pairs);
		push_frame(SAMPLE_MIN, SAMPLE_MAX);
		push_frame(SAMPLE_MIN, SAMPLE_MIN);
		push_frame(SAMPLE_MAX, '0);
	endtask

	// extreme feedback makes the recursion blow up: delay words and section
	// outputs have to clip at the 48-bit limits
	task automatic test_coef_extremes();
		reg_word_t pairs [SECTIONS];
		pairs = '{default: COEF_MAX_PAIR};
		load_settings(GAIN_MAX, pairs);
		push_frame(SAMPLE_MAX, SAMPLE_MIN);
		push_frame(SAMPLE_MIN, SAMPLE_MAX);
		push_frame(SAMPLE_MAX, SAMPLE_MAX);
		push_frame('0, '0);
		pairs = '{default: COEF_MIN_PAIR};
		load_settings(GAIN_MIN, pairs);
		push_frame(SAMPLE_MIN, SAMPLE_MAX);
		push_frame(SAMPLE_MAX, SAMPLE_MIN);
		push_frame(-1, 1);
	endtask

	// writes past the register list must leave the delay words alone;
	// rewriting a listed register with the same value still flushes them
	task automatic test_index_decode();
		reg_word_t  pairs [SECTIONS];
		gain_word_t g;
		foreach (pairs[s])
			pairs[s] = stable_pair();
		g = random_gain(1'b0);
		load_settings(g, pairs);
		push_frame(SAMPLE_MAX, SAMPLE_MIN);
		push_frame(random_sample(), random_sample());
		wait_drained();
		write_reg(IDX_PAST_LIST, {$urandom, $urandom});
		write_reg(IDX_TOP, '1);
		cfg.valid <= 1'b0;
		push_frame(random_sample(), random_sample());
		push_frame(random_sample(), random_sample());
		push_frame(random_sample(), random_sample());
		wait_drained();
		write_reg(CFG_GAIN, {{GAIN_BITS{1'b0}}, g});
		cfg.valid <= 1'b0;
		push_frame(random_sample(), random_sample());
	endtask

	// stable band-pass settings, a fresh one per phase, each phase with its
	// own mix of idling; phase 0 stops halfway until everything is back
	task automatic test_random_bandpass();
		reg_word_t pairs [SECTIONS];
		for (int phase = 0; phase < 4; phase++) begin
			foreach (pairs[s])
				pairs[s] = stable_pair();
			load_settings(random_gain(phase % 2 == 1), pairs);
			tx_no_idle = (phase == 1 || phase == 2);
			rx_no_idle = (phase == 1 || phase == 3);
			for (int n = 0; n < 80; n++) begin
				if (phase == 0 && n == 40)
					wait_drained();
				push_frame(random_sample(), random_sample());
			end
		end
		tx_no_idle = 1'b0;
		rx_no_idle = 1'b0;
	endtask

	// every register bit random, saturation likely anywhere in the cascade
	task automatic test_random_registers();
		reg_word_t pairs [SECTIONS];
		for (int phase = 0; phase < 2; phase++) begin
			foreach (pairs[s])
				pairs[s] = {$urandom, $urandom};
			load_settings(random_gain(1'b1), pairs);
			for (int n = 0; n < 30; n++)
				push_frame(random_sample(), random_sample());
		end
	endtask

	// the result side stops for a long stretch while frames keep coming,
	// so the output register and the datapath fill and input ready drops
	task automatic test_result_backpressure();
		reg_word_t pairs [SECTIONS];
		foreach (pairs[s])
			pairs[s] = stable_pair();
		load_settings(random_gain(1'b0), pairs);
		tx_no_idle = 1'b1;
		rx_hold    = HOLD_CYCLES;
		for (int n = 0; n < 16; n++)
			push_frame(random_sample(), random_sample());
		tx_no_idle = 1'b0;
		for (int n = 0; n < 24; n++) begin
			if (n == 12)
				wait_drained();
			push_frame(random_sample(), random_sample());
		end
	endtask

	// ------------------------------------------------------------------
	// Result side: random ready, optional long hold, in-order checking
	// ------------------------------------------------------------------
	initial begin : result_side
		frame_t      want;
		int unsigned wait_left;
		wait_left       = 0;
		result_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (result_ch.valid && result_ch.ready) begin
				if (filtered_pending.size() == 0) begin
					log_error($sformatf("frame with nothing owed: left %0d right %0d",
						result_ch.left_out, result_ch.right_out));
				end else begin
					want = filtered_pending.pop_front();
					if (result_ch.left_out !== want.left)
						log_error($sformatf("frame %0d left: expected %0d got %0d",
							results_checked, want.left, result_ch.left_out));
					if (result_ch.right_out !== want.right)
						log_error($sformatf("frame %0d right: expected %0d got %0d",
							results_checked, want.right, result_ch.right_out));
				end
				results_checked++;
				wait_left = rx_no_idle ? 0 : $urandom_range(MAX_GAP, 0);
			end
			// the long hold counts down here, apart from the per-frame gaps
			if (rx_hold != 0) begin
				rx_hold--;
				result_ch.ready <= 1'b0;
			end else if (wait_left != 0) begin
				wait_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: too long without any transaction on any channel
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) ||
				(cfg.valid && cfg.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles, %0d frames owed",
				WATCHDOG_LIMIT, filtered_pending.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin : stimulus
		sample_ch.valid        = 1'b0;
		sample_ch.left_sample  = '0;
		sample_ch.right_sample = '0;
		cfg.valid              = 1'b0;
		cfg.index              = '0;
		cfg.data               = '0;
		gain_q31               = '0;
		foreach (fb_old[s]) begin
			fb_old[s] = '0;
			fb_new[s] = '0;
		end
		clear_delay_words();

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_gain_extremes();
		test_coef_extremes();
		test_index_decode();
		test_random_bandpass();
		test_random_registers();
		test_result_backpressure();

		// let the last frame out, then watch for anything extra
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Filtered %0d stereo frames over %0d register settings (%0d register writes),",
			frames_sent, settings_loaded, reg_writes);
		$display("with random idling, one long result stall; %0d frames checked, %0d mismatches.",
			results_checked, err_count);
		if (err_count == 0 && filtered_pending.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/sbbc_pkg.sv
hw/rtl/sbbc_in_if.sv
hw/rtl/sbbc_out_if.sv
hw/rtl/sbbc_cfg_if.sv
hw/rtl/sbbc_seq.sv
hw/rtl/sbbc_dpath.sv
hw/rtl/stereo_bessel_bandpass_cascade_top.sv
dv/tb_stereo_bessel_bandpass_cascade_top.sv
